/* sv/wpsd_pkg.sv */
// Shared types and constants for the WAV PCM stream parser.
package wpsd_pkg;

   // Result kinds.
   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;
   localparam logic [1:0] KIND_END    = 2'd3;

   // Four-character tags as they appear in byte order, first byte in the top.
   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam logic [15:0] DAC_MIDPOINT = 16'h8000;
   localparam logic [31:0] FMT_MIN_LEN  = 32'd16;
   localparam logic [15:0] FMT_PCM      = 16'd1;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] sample;
      logic [31:0]        dac_word;
      logic [15:0]        channel_count;
      logic [31:0]        rate_hz;
      logic [15:0]        sample_bits;
      logic               last;
   } result_type;

endpackage

/* sv/wpsd_stream_if.sv */
// Handshake channels for file bytes in and parser results out.
interface wpsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wpsd_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic signed [15:0] sample;
   logic [31:0]        dac_word;
   logic [15:0]        channel_count;
   logic [31:0]        rate_hz;
   logic [15:0]        sample_bits;
   logic               last;

   modport source (output valid, output kind, output sample, output dac_word,
                   output channel_count, output rate_hz, output sample_bits,
                   output last, input ready);
   modport sink   (input valid, input kind, input sample, input dac_word,
                   input channel_count, input rate_hz, input sample_bits,
                   input last, output ready);
endinterface

/* sv/wav_pcm_stream_to_dac.sv */
// Streaming RIFF/WAVE parser that turns linear PCM bytes into samples and DAC words.
//
//  channel | dir | handshake     | item
//  --------+-----+---------------+--------------------------------------------
//  req_ch  | in  | valid/ready   | one file byte plus end-of-file flag
//  rsp_ch  | out | valid/ready   | one result: sample, header ok, reject, end
//
// A byte is parsed while it sits in the input register, once the queue has room for its results.
// Its results are registered into a four-entry queue, and a new byte is taken every cycle
// while the result side keeps up.
// A byte makes at most two results and is parsed only while the queue has room for two.
// The queue drains one result per cycle; a stalled result side fills it, holds the input
// register and drops req_ch.ready. Synchronous reset clears the parser and empties the queue.
module wav_pcm_stream_to_dac
   import wpsd_pkg::*;
(
   input logic         clock,
   input logic         reset,
   wpsd_req_if.sink    req_ch,
   wpsd_rsp_if.source  rsp_ch
);

   // Parser phases.
   localparam logic [2:0] PH_RIFF = 3'd0;
   localparam logic [2:0] PH_SIZE = 3'd1;
   localparam logic [2:0] PH_WAVE = 3'd2;
   localparam logic [2:0] PH_HDR  = 3'd3;
   localparam logic [2:0] PH_FMT  = 3'd4;
   localparam logic [2:0] PH_SKIP = 3'd5;
   localparam logic [2:0] PH_DATA = 3'd6;
   localparam logic [2:0] PH_DONE = 3'd7;

   // Builds one result. Fields that do not belong to a kind read as zero.
   function automatic result_type make_result(input logic [1:0]  kind,
                                              input logic [15:0] smp,
                                              input logic [15:0] chan,
                                              input logic [31:0] rate,
                                              input logic [15:0] bits);
      result_type r;
      r = '0;
      r.kind = kind;
      if (kind == KIND_SAMPLE) begin
         r.sample   = smp;
         r.dac_word = {DAC_MIDPOINT - smp, smp ^ DAC_MIDPOINT};
      end
      if (kind == KIND_SAMPLE || kind == KIND_HEADER) begin
         r.channel_count = chan;
         r.rate_hz       = rate;
         r.sample_bits   = bits;
      end
      return r;
   endfunction

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // Parser state.
   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  offset_ff, offset_in;   // file offset, saturating; only 0..11 matter
   logic [31:0] tag_ff, tag_in;
   logic [31:0] len_ff, len_in;
   logic [32:0] pos_ff, pos_in;
   logic [15:0] chan_ff, chan_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] bits_ff, bits_in;
   logic [31:0] left_ff, left_in;
   logic [7:0]  low_ff, low_in;
   logic [1:0]  idx_ff, idx_in;

   // Result queue.
   result_type q_ff [0:3];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;

   logic       req_fire;
   logic       proc_fire;
   logic       pop;
   logic       res_a_valid, res_b_valid;
   result_type res_a, res_b;
   result_type push_first, push_second;
   logic [1:0] push_n;

   logic        bad;
   logic        eight_bit;
   logic        frame_end;
   logic [32:0] pos_next;
   logic [32:0] chunk_total;
   logic [15:0] smp;

   // A byte is parsed only when the queue can take both of its possible results.
   assign proc_fire    = in_valid_ff && (count_ff <= 3'd2);
   assign req_ch.ready = !in_valid_ff || proc_fire;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign pop          = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (proc_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_ch.data_byte;
         in_last_ff <= req_ch.last_byte;
      end
   end

   // Parser: one byte per cycle while the queue has room, at most two results per byte.
   always_comb begin
      phase_in  = phase_ff;
      offset_in = offset_ff;
      tag_in    = tag_ff;
      len_in    = len_ff;
      pos_in    = pos_ff;
      chan_in   = chan_ff;
      rate_in   = rate_ff;
      bits_in   = bits_ff;
      left_in   = left_ff;
      low_in    = low_ff;
      idx_in    = idx_ff;

      bad         = 1'b0;
      res_a_valid = 1'b0;
      res_b_valid = 1'b0;
      res_a       = '0;
      res_b       = '0;
      smp         = '0;

      eight_bit   = (bits_ff == 16'd8);
      pos_next    = pos_ff + 33'd1;
      chunk_total = {1'b0, len_ff} + {32'd0, len_ff[0]};

      // Last byte of a frame: one or two channels, one or two bytes each.
      if (eight_bit) begin
         frame_end = (chan_ff == 16'd2) ? (idx_ff == 2'd1) : (idx_ff == 2'd0);
      end else begin
         frame_end = (chan_ff == 16'd2) ? (idx_ff == 2'd3) : (idx_ff == 2'd1);
      end

      if (proc_fire) begin
         if (offset_ff != 4'hF) begin
            offset_in = offset_ff + 4'd1;
         end

         case (phase_ff)
            PH_RIFF, PH_SIZE, PH_WAVE: begin
               tag_in = {tag_ff[23:0], in_byte_ff};
               if (offset_ff == 4'd3) begin
                  if (tag_in != TAG_RIFF) begin
                     bad = 1'b1;
                  end else begin
                     phase_in = PH_SIZE;
                  end
               end else if (offset_ff == 4'd7) begin
                  phase_in = PH_WAVE;
               end else if (offset_ff == 4'd11) begin
                  if (tag_in != TAG_WAVE) begin
                     bad = 1'b1;
                  end else begin
                     phase_in = PH_HDR;
                     pos_in   = '0;
                  end
               end
            end

            PH_HDR: begin
               // Chunk header: four tag bytes, then a little-endian length.
               if (!pos_ff[2]) begin
                  tag_in = {tag_ff[23:0], in_byte_ff};
               end else begin
                  len_in = {in_byte_ff, len_ff[31:8]};
               end
               pos_in = pos_next;
               if (pos_ff[2:0] == 3'd7) begin
                  pos_in = '0;
                  if (tag_in == TAG_DATA) begin
                     if (len_in == 32'd0 || in_last_ff) begin
                        bad = 1'b1;
                     end else begin
                        left_in     = len_in;
                        idx_in      = '0;
                        phase_in    = PH_DATA;
                        res_a_valid = 1'b1;
                        res_a       = make_result(KIND_HEADER, '0, chan_ff, rate_ff,
                                                  bits_ff);
                     end
                  end else if (tag_in == TAG_FMT && len_in < FMT_MIN_LEN) begin
                     bad = 1'b1;
                  end else if (len_in != 32'd0) begin
                     phase_in = (tag_in == TAG_FMT) ? PH_FMT : PH_SKIP;
                  end
               end
            end

            PH_FMT, PH_SKIP: begin
               if (phase_ff == PH_FMT && pos_ff[32:4] == '0) begin
                  case (pos_ff[3:0])
                     4'd0: low_in = in_byte_ff;
                     4'd1: begin
                        if ({in_byte_ff, low_ff} != FMT_PCM) begin
                           bad = 1'b1;
                        end
                     end
                     4'd2: chan_in[7:0]  = in_byte_ff;
                     4'd3: chan_in[15:8] = in_byte_ff;
                     4'd4, 4'd5, 4'd6, 4'd7: begin
                        rate_in[{pos_ff[1:0], 3'b000} +: 8] = in_byte_ff;
                     end
                     4'd14: bits_in[7:0]  = in_byte_ff;
                     4'd15: bits_in[15:8] = in_byte_ff;
                     default: ;
                  endcase
               end
               if (!bad) begin
                  // Odd lengths carry one pad byte.
                  if (pos_next >= chunk_total) begin
                     pos_in   = '0;
                     phase_in = PH_HDR;
                  end else begin
                     pos_in = pos_next;
                  end
               end
            end

            PH_DATA: begin
               if (eight_bit && idx_ff == 2'd0) begin
                  smp         = {in_byte_ff ^ 8'h80, 8'h00};
                  res_a_valid = 1'b1;
               end else if (!eight_bit && idx_ff == 2'd0) begin
                  low_in = in_byte_ff;
               end else if (!eight_bit && idx_ff == 2'd1) begin
                  smp         = {in_byte_ff, low_ff};
                  res_a_valid = 1'b1;
               end
               res_a  = make_result(KIND_SAMPLE, smp, chan_ff, rate_ff, bits_ff);
               idx_in = frame_end ? 2'd0 : idx_ff + 2'd1;
               left_in = left_ff - 32'd1;
               if (left_ff == 32'd1 || in_last_ff) begin
                  res_b_valid = 1'b1;
                  res_b       = make_result(KIND_END, '0, '0, '0, '0);
                  phase_in    = PH_DONE;
               end
            end

            default: ;
         endcase

         if (bad) begin
            res_b_valid = 1'b1;
            res_b       = make_result(KIND_REJECT, '0, '0, '0, '0);
            phase_in    = PH_DONE;
         end
         // A file that ends before its data chunk is rejected once.
         if (in_last_ff && phase_in != PH_DONE && phase_in != PH_DATA) begin
            res_b_valid = 1'b1;
            res_b       = make_result(KIND_REJECT, '0, '0, '0, '0);
         end

         // The final byte of a file returns the parser to its start state.
         if (in_last_ff) begin
            phase_in  = PH_RIFF;
            offset_in = '0;
            tag_in    = '0;
            len_in    = '0;
            pos_in    = '0;
            chan_in   = '0;
            rate_in   = '0;
            bits_in   = '0;
            left_in   = '0;
            idx_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_RIFF;
         offset_ff <= '0;
         tag_ff    <= '0;
         len_ff    <= '0;
         pos_ff    <= '0;
         chan_ff   <= '0;
         rate_ff   <= '0;
         bits_ff   <= '0;
         left_ff   <= '0;
         idx_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         offset_ff <= offset_in;
         tag_ff    <= tag_in;
         len_ff    <= len_in;
         pos_ff    <= pos_in;
         chan_ff   <= chan_in;
         rate_ff   <= rate_in;
         bits_ff   <= bits_in;
         left_ff   <= left_in;
         idx_ff    <= idx_in;
      end
   end

   // The held low byte is always written before it is read.
   always_ff @(posedge clock) begin
      low_ff <= low_in;
   end

   // Pack the results of one byte in order; the last one carries the flag.
   always_comb begin
      push_n      = {1'b0, res_a_valid} + {1'b0, res_b_valid};
      push_first  = res_a_valid ? res_a : res_b;
      push_second = res_b;
      push_first.last  = (push_n == 2'd1);
      push_second.last = 1'b1;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_n;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, push_n} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         q_ff[wr_ptr_ff] <= push_first;
      end
      if (push_n == 2'd2) begin
         q_ff[wr_ptr_ff + 2'd1] <= push_second;
      end
   end

   assign rsp_ch.valid         = (count_ff != 3'd0);
   assign rsp_ch.kind          = q_ff[rd_ptr_ff].kind;
   assign rsp_ch.sample        = q_ff[rd_ptr_ff].sample;
   assign rsp_ch.dac_word      = q_ff[rd_ptr_ff].dac_word;
   assign rsp_ch.channel_count = q_ff[rd_ptr_ff].channel_count;
   assign rsp_ch.rate_hz       = q_ff[rd_ptr_ff].rate_hz;
   assign rsp_ch.sample_bits   = q_ff[rd_ptr_ff].sample_bits;
   assign rsp_ch.last          = q_ff[rd_ptr_ff].last;

`ifndef ASSERT_OFF
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("result queue overflow");

   a_room_on_parse: assert property (@(posedge clock) disable iff (reset)
      (push_n != 2'd0) |-> (count_ff <= 3'd2))
      else $error("results pushed without room");

   a_restart_after_eof: assert property (@(posedge clock) disable iff (reset)
      (proc_fire && in_last_ff) |=> (phase_ff == PH_RIFF && offset_ff == 4'd0))
      else $error("parser did not restart after end of file");

   a_data_left_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (left_ff != 32'd0))
      else $error("data phase with no bytes left");
`endif

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the streaming WAV PCM parser: predicts every result per file byte.
import wpsd_pkg::*;

// Where the parser stands inside one file.
typedef enum logic [3:0] {
   STEP_PREAMBLE,
   STEP_CHUNK_HDR,
   STEP_FMT,
   STEP_SKIP,
   STEP_DATA,
   STEP_DONE
} parse_step_type;

// Tracks the parser as file bytes go in and checks results as they come out.
class wav_result_tracker_type;
   result_type   due_results[$];
   int unsigned  faults;
   int unsigned  checked;

   parse_step_type step;
   logic [31:0]  offset;
   logic [31:0]  tag;
   logic [31:0]  len;
   logic [32:0]  pos;
   logic [15:0]  chans;
   logic [31:0]  rate;
   logic [15:0]  bits;
   logic [31:0]  left;
   logic [7:0]   low;
   logic [1:0]   fidx;

   function new();
      faults  = 0;
      checked = 0;
      clear();
   endfunction

   function void clear();
      step   = STEP_PREAMBLE;
      offset = '0;
      tag    = '0;
      len    = '0;
      pos    = '0;
      chans  = '0;
      rate   = '0;
      bits   = '0;
      left   = '0;
      low    = '0;
      fidx   = '0;
   endfunction

   function void emit(logic [1:0] kind, logic [15:0] value);
      result_type r;
      r = '0;
      r.kind = kind;
      if (kind == KIND_SAMPLE) begin
         r.sample   = value;
         r.dac_word = {DAC_MIDPOINT - value, value + DAC_MIDPOINT};
      end
      if (kind == KIND_SAMPLE || kind == KIND_HEADER) begin
         r.channel_count = chans;
         r.rate_hz       = rate;
         r.sample_bits   = bits;
      end
      due_results.push_back(r);
   endfunction

   // Advances the parser by one byte. Returns 1 when the byte was parsed.
   function bit note_byte(logic [7:0] b, logic fin);
      bit          bad;
      bit          wide;
      bit          live;
      logic [31:0] at;
      logic [32:0] span;
      int unsigned made;
      int unsigned frame_len;
      int unsigned idx;
      result_type  r;

      bad  = 1'b0;
      live = (step != STEP_DONE);
      made = due_results.size();
      at   = offset;
      if (offset != 32'hFFFF_FFFF) offset = offset + 32'd1;

      case (step)
         STEP_PREAMBLE: begin
            tag = {tag[23:0], b};
            if (at == 32'd3) begin
               if (tag != TAG_RIFF) bad = 1'b1;
            end else if (at == 32'd11) begin
               if (tag != TAG_WAVE) begin
                  bad = 1'b1;
               end else begin
                  step = STEP_CHUNK_HDR;
                  pos  = '0;
               end
            end
         end
         STEP_CHUNK_HDR: begin
            // Tag arrives first byte first, the length little-endian.
            if (pos < 33'd4) tag = {tag[23:0], b};
            else len = {b, len[31:8]};
            pos = pos + 33'd1;
            if (pos == 33'd8) begin
               pos = '0;
               if (tag == TAG_DATA) begin
                  if (len == 32'd0 || fin) begin
                     bad = 1'b1;
                  end else begin
                     left = len;
                     fidx = '0;
                     step = STEP_DATA;
                     emit(KIND_HEADER, 16'd0);
                  end
               end else if (tag == TAG_FMT && len < FMT_MIN_LEN) begin
                  bad = 1'b1;
               end else if (len != 32'd0) begin
                  step = (tag == TAG_FMT) ? STEP_FMT : STEP_SKIP;
               end
            end
         end
         STEP_FMT, STEP_SKIP: begin
            if (step == STEP_FMT && pos < 33'd16) begin
               case (pos[3:0])
                  4'd0:  low = b;
                  4'd1:  if ({b, low} != FMT_PCM) bad = 1'b1;
                  4'd2:  chans[7:0]   = b;
                  4'd3:  chans[15:8]  = b;
                  4'd4:  rate[7:0]    = b;
                  4'd5:  rate[15:8]   = b;
                  4'd6:  rate[23:16]  = b;
                  4'd7:  rate[31:24]  = b;
                  4'd14: bits[7:0]    = b;
                  4'd15: bits[15:8]   = b;
                  default: ;
               endcase
            end
            if (!bad) begin
               // Odd lengths carry one pad byte; the sum needs 33 bits.
               span = {1'b0, len} + {32'd0, len[0]};
               pos  = pos + 33'd1;
               if (pos >= span) begin
                  pos  = '0;
                  step = STEP_CHUNK_HDR;
               end
            end
         end
         STEP_DATA: begin
            wide      = (bits != 16'd8);
            frame_len = (wide ? 2 : 1) * ((chans == 16'd2) ? 2 : 1);
            idx       = fidx;
            if (!wide && idx == 0) emit(KIND_SAMPLE, {b ^ 8'h80, 8'h00});
            else if (wide && idx == 0) low = b;
            else if (wide && idx == 1) emit(KIND_SAMPLE, {b, low});
            idx = idx + 1;
            if (idx >= frame_len) idx = 0;
            fidx = 2'(idx);
            left = left - 32'd1;
            if (left == 32'd0 || fin) begin
               emit(KIND_END, 16'd0);
               step = STEP_DONE;
            end
         end
         default: ;
      endcase

      if (bad) begin
         emit(KIND_REJECT, 16'd0);
         step = STEP_DONE;
      end
      if (fin && step != STEP_DONE && step != STEP_DATA) emit(KIND_REJECT, 16'd0);
      if (due_results.size() > made) begin
         r = due_results.pop_back();
         r.last = 1'b1;
         due_results.push_back(r);
      end
      if (fin) clear();
      return live;
   endfunction

   task log_fault(string msg);
      faults++;
      $display("mismatch: %s", msg);
   endtask

   task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         log_fault($sformatf("result %0d %s got 0x%0h want 0x%0h", checked, name, got, want));
   endtask

   task check(result_type got);
      result_type want;
      if (due_results.size() == 0) begin
         log_fault($sformatf("result %0d kind %0d arrived with nothing due", checked, got.kind));
      end else begin
         want = due_results.pop_front();
         compare_field("kind",          32'(got.kind),          32'(want.kind));
         compare_field("sample",        32'(got.sample),        32'(want.sample));
         compare_field("dac_word",      got.dac_word,           want.dac_word);
         compare_field("channel_count", 32'(got.channel_count), 32'(want.channel_count));
         compare_field("rate_hz",       got.rate_hz,            want.rate_hz);
         compare_field("sample_bits",   32'(got.sample_bits),   32'(want.sample_bits));
         compare_field("last",          32'(got.last),          32'(want.last));
      end
      checked++;
   endtask
endclass

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import wpsd_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wpsd_req_if req_ch ();
   wpsd_rsp_if rsp_ch ();

   wav_pcm_stream_to_dac dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   wav_result_tracker_type tracker = new();

   // The file being sent, one byte per entry; the final entry carries last_byte.
   logic [7:0]  wav_bytes[$];
   // Bytes that the parser actually worked on; ignored bytes do not count.
   int unsigned live_bytes = 0;
   // When set, the side concerned never idles, which gives back-to-back stretches.
   bit          req_burst  = 1'b0;
   bit          rsp_burst  = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned draw_gap(bit burst);
      return burst ? 0 : $urandom_range(0, 15);
   endfunction

   // Four-character tags go out first character first; numbers go out little-endian.
   function automatic void add_tag(logic [31:0] t);
      wav_bytes.push_back(t[31:24]);
      wav_bytes.push_back(t[23:16]);
      wav_bytes.push_back(t[15:8]);
      wav_bytes.push_back(t[7:0]);
   endfunction

   function automatic void add_le16(logic [15:0] v);
      wav_bytes.push_back(v[7:0]);
      wav_bytes.push_back(v[15:8]);
   endfunction

   function automatic void add_le32(logic [31:0] v);
      add_le16(v[15:0]);
      add_le16(v[31:16]);
   endfunction

   function automatic void add_noise(int unsigned count);
      repeat (count) wav_bytes.push_back(8'($urandom));
   endfunction

   // Builds one random file. Most files are well formed with random content, so
   // that the parser gets deep into the data chunk; a share is truncated,
   // corrupted, or plain noise.
   function automatic void make_random_file();
      int unsigned pick;
      int unsigned junk_len;
      int unsigned fmt_len;
      int unsigned data_len;
      int unsigned cut;
      bit          huge;
      logic [15:0] code;
      logic [15:0] chan_field;
      logic [15:0] bits_field;

      wav_bytes.delete();
      if ($urandom_range(0, 19) == 0) begin
         add_noise($urandom_range(1, 16));
         return;
      end

      add_tag(TAG_RIFF);
      add_le32($urandom);
      add_tag(TAG_WAVE);

      // Unknown chunks ahead of the format chunk, odd lengths padded to even.
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 2)) begin
            junk_len = $urandom_range(0, 5);
            add_tag($urandom);
            add_le32(junk_len);
            add_noise(junk_len + junk_len % 2);
         end
      end

      if ($urandom_range(0, 9) != 0) begin
         pick    = $urandom_range(0, 9);
         fmt_len = (pick < 8) ? 16 : (pick == 8) ? $urandom_range(17, 19)
                                                 : $urandom_range(0, 15);
         add_tag(TAG_FMT);
         add_le32(fmt_len);
         if (fmt_len < 16) begin
            // The parser rejects the file at the end of this chunk header.
            add_noise($urandom_range(0, 3));
            return;
         end
         code = ($urandom_range(0, 19) == 0) ? 16'($urandom) : FMT_PCM;
         case ($urandom_range(0, 3))
            0:       chan_field = 16'd1;
            3:       chan_field = 16'($urandom);
            default: chan_field = 16'd2;
         endcase
         case ($urandom_range(0, 5))
            0, 1:    bits_field = 16'd8;
            2, 3:    bits_field = 16'd16;
            4:       bits_field = 16'd24;
            default: bits_field = 16'($urandom);
         endcase
         add_le16(code);
         add_le16(chan_field);
         add_le32($urandom);
         add_le32($urandom);
         add_le16(16'($urandom));
         add_le16(bits_field);
         add_noise(fmt_len + fmt_len % 2 - 16);
      end

      // Data chunk: usually short, now and then empty or far longer than the file.
      add_tag(TAG_DATA);
      pick = $urandom_range(0, 19);
      huge = (pick == 1);
      data_len = (pick == 0) ? 0 : huge ? $urandom_range(32'h0001_0000, 32'hFFFF_FFFF)
                                        : $urandom_range(1, 16);
      add_le32(data_len);
      if (huge) begin
         add_noise($urandom_range(0, 12));
      end else begin
         add_noise(data_len);
         add_noise($urandom_range(0, 4));
      end

      case ($urandom_range(0, 9))
         0: begin
            cut = $urandom_range(1, wav_bytes.size());
            while (wav_bytes.size() > cut) void'(wav_bytes.pop_back());
         end
         1: wav_bytes[$urandom_range(0, wav_bytes.size() - 1)] = 8'($urandom);
         default: ;
      endcase
   endfunction

   // Offers one byte after a random pause and holds it until the parser takes it.
   // The handshake is judged at the falling edge, where valid and ready are settled.
   task automatic send_byte(logic [7:0] b, logic fin);
      int unsigned gap;
      gap = draw_gap(req_burst);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.last_byte <= fin;
      do @(negedge clock); while (!req_ch.ready);
      live_bytes += tracker.note_byte(b, fin);
      @(posedge clock);
   endtask

   task automatic send_file();
      for (int i = 0; i < wav_bytes.size(); i++)
         send_byte(wav_bytes[i], i == wav_bytes.size() - 1);
   endtask

   // Result side: ready drops for a random stretch before each item, then stays
   // high until an item has been taken.
   initial begin
      int unsigned gap;
      rsp_ch.ready <= 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         gap = draw_gap(rsp_burst);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(negedge clock); while (!rsp_ch.valid);
         @(posedge clock);
      end
   end

   // Every result taken is compared against the oldest prediction.
   always @(negedge clock) begin : result_watch
      result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.kind          = rsp_ch.kind;
         got.sample        = rsp_ch.sample;
         got.dac_word      = rsp_ch.dac_word;
         got.channel_count = rsp_ch.channel_count;
         got.rate_hz       = rsp_ch.rate_hz;
         got.sample_bits   = rsp_ch.sample_bits;
         got.last          = rsp_ch.last;
         tracker.check(got);
      end
   end

   initial begin
      req_ch.valid     <= 1'b0;
      req_ch.data_byte <= 8'd0;
      req_ch.last_byte <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // 8-bit stereo with a padded odd chunk ahead of the format chunk. The last
      // data byte gives both a sample and the end of data; the chunk after the
      // data is ignored.
      wav_bytes.delete();
      add_tag(TAG_RIFF);
      add_le32(32'hFFFF_FFFF);
      add_tag(TAG_WAVE);
      add_tag(32'h4A55_4E4B);
      add_le32(32'd1);
      add_noise(2);
      add_tag(TAG_FMT);
      add_le32(FMT_MIN_LEN);
      add_le16(FMT_PCM);
      add_le16(16'd2);
      add_le32(32'hFFFF_FFFF);
      add_le32(32'd0);
      add_le16(16'd2);
      add_le16(16'd8);
      add_tag(TAG_DATA);
      add_le32(32'd5);
      wav_bytes.push_back(8'h00);
      wav_bytes.push_back(8'h11);
      wav_bytes.push_back(8'hFF);
      wav_bytes.push_back(8'h22);
      wav_bytes.push_back(8'h80);
      add_tag(32'h4C49_5354);
      add_le32(32'd3);
      send_file();

      // No format chunk: the fields must be back at zero and the data read as
      // 16-bit mono, taking both extremes of the sample range.
      wav_bytes.delete();
      add_tag(TAG_RIFF);
      add_le32(32'd0);
      add_tag(TAG_WAVE);
      add_tag(TAG_DATA);
      add_le32(32'd4);
      add_le16(16'h8000);
      add_le16(16'h7FFF);
      send_file();

      // Wrong RIFF tag, ending on the tag itself.
      wav_bytes.delete();
      add_tag(32'h5249_4658);
      send_file();

      // Format code other than PCM; the file ends on the code byte.
      wav_bytes.delete();
      add_tag(TAG_RIFF);
      add_le32(32'd36);
      add_tag(TAG_WAVE);
      add_tag(TAG_FMT);
      add_le32(FMT_MIN_LEN);
      add_le16(16'd3);
      send_file();

      // Format chunk shorter than its minimum, ending on its length.
      wav_bytes.delete();
      add_tag(TAG_RIFF);
      add_le32(32'd36);
      add_tag(TAG_WAVE);
      add_tag(TAG_FMT);
      add_le32(32'd14);
      send_file();

      // The file stops right after the WAVE tag, before any data chunk.
      wav_bytes.delete();
      add_tag(TAG_RIFF);
      add_le32(32'd4);
      add_tag(TAG_WAVE);
      send_file();

      while (live_bytes < 600) begin
         req_burst = ($urandom_range(0, 3) == 0);
         rsp_burst = ($urandom_range(0, 3) == 0);
         make_random_file();
         send_file();
      end
      req_ch.valid <= 1'b0;

      // Drain everything still due, then give the parser time to show any extra result.
      rsp_burst = 1'b1;
      while (tracker.due_results.size() != 0) @(posedge clock);
      repeat (32) @(posedge clock);
      if (tracker.faults == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   // Ends a run that hangs, far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end
endmodule
